// ----- rtl/core/fwkd_pkg.sv -----
// Shared types and constants for the five-way key event detector.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package fwkd_pkg;

  // Event codes, also used for the direction of the joystick
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UP     = 3'd1,
    EV_DOWN   = 3'd2,
    EV_LEFT   = 3'd3,
    EV_RIGHT  = 3'd4,
    EV_CLICK  = 3'd5,
    EV_DOUBLE = 3'd6,
    EV_LONG   = 3'd7
  } event_t;

  // Center key phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HELD     = 3'd2,
    PH_RELEASED = 3'd3,
    PH_WAIT_UP  = 3'd4
  } phase_t;

  // Register map (word index)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_DOUBLE   = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd2;
  localparam logic [15:0] LONG_RST     = 16'd100;
  localparam logic [15:0] DOUBLE_RST   = 16'd30;

  // ADC windows, all bounds exclusive
  localparam logic [11:0] LEFT_LO  = 12'd4000;
  localparam logic [11:0] RIGHT_LO = 12'd1900;
  localparam logic [11:0] RIGHT_HI = 12'd2200;
  localparam logic [11:0] UP_LO    = 12'd900;
  localparam logic [11:0] UP_HI    = 12'd1200;
  localparam logic [11:0] DOWN_LO  = 12'd1250;
  localparam logic [11:0] DOWN_HI  = 12'd1550;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] second_press_ticks;
  } cfg_t;

  // Center key step result
  typedef struct packed {
    phase_t      phase;
    logic [15:0] timer;
    logic        fire;
    event_t      code;
  } center_step_t;

endpackage

// ----- rtl/core/fwkd_dir_classify.sv -----
// Maps a joystick ADC sample to a direction code.
// Depends on fwkd_pkg.
`timescale 1ns / 1ps

module fwkd_dir_classify (
  input  logic [11:0]      adc_sample,
  output fwkd_pkg::event_t dir
);

  // Windows checked in priority order
  always_comb begin
    if (adc_sample > fwkd_pkg::LEFT_LO) begin
      dir = fwkd_pkg::EV_LEFT;
    end else if (adc_sample > fwkd_pkg::RIGHT_LO && adc_sample < fwkd_pkg::RIGHT_HI) begin
      dir = fwkd_pkg::EV_RIGHT;
    end else if (adc_sample > fwkd_pkg::UP_LO && adc_sample < fwkd_pkg::UP_HI) begin
      dir = fwkd_pkg::EV_UP;
    end else if (adc_sample > fwkd_pkg::DOWN_LO && adc_sample < fwkd_pkg::DOWN_HI) begin
      dir = fwkd_pkg::EV_DOWN;
    end else begin
      dir = fwkd_pkg::EV_NONE;
    end
  end

endmodule

// ----- rtl/core/fwkd_center_fsm.sv -----
// Next-state logic of the center key phase machine and its tick timer.
// Depends on fwkd_pkg; state registers live in the top level.
`timescale 1ns / 1ps

module fwkd_center_fsm (
  input  fwkd_pkg::phase_t       phase,
  input  logic [15:0]            timer,
  input  logic                   pressed,
  input  fwkd_pkg::cfg_t         cfg,
  output fwkd_pkg::center_step_t step
);

  logic [15:0] timer_inc;

  // Timer advances every scan unless a phase clears it, and wraps
  assign timer_inc = timer + 16'd1;

  always_comb begin
    step.phase = phase;
    step.timer = timer_inc;
    step.fire  = 1'b0;
    step.code  = fwkd_pkg::EV_NONE;
    case (phase)
      fwkd_pkg::PH_IDLE: begin
        if (pressed) begin
          step.timer = '0;
          step.phase = fwkd_pkg::PH_DEBOUNCE;
        end
      end
      fwkd_pkg::PH_DEBOUNCE: begin
        if (!pressed) begin
          step.phase = fwkd_pkg::PH_IDLE;
        end else if (timer_inc >= cfg.settle_ticks) begin
          step.phase = fwkd_pkg::PH_HELD;
        end
      end
      fwkd_pkg::PH_HELD: begin
        if (!pressed) begin
          step.timer = '0;
          step.phase = fwkd_pkg::PH_RELEASED;
        end else if (timer_inc >= cfg.hold_ticks) begin
          step.phase = fwkd_pkg::PH_WAIT_UP;
          step.fire  = 1'b1;
          step.code  = fwkd_pkg::EV_LONG;
        end
      end
      fwkd_pkg::PH_RELEASED: begin
        if (timer_inc > cfg.second_press_ticks) begin
          step.phase = fwkd_pkg::PH_IDLE;
          step.fire  = 1'b1;
          step.code  = fwkd_pkg::EV_CLICK;
        end else if (pressed) begin
          step.phase = fwkd_pkg::PH_WAIT_UP;
          step.fire  = 1'b1;
          step.code  = fwkd_pkg::EV_DOUBLE;
        end
      end
      fwkd_pkg::PH_WAIT_UP: begin
        if (!pressed) begin
          step.phase = fwkd_pkg::PH_IDLE;
        end
      end
      default: begin
        // unreachable phase codes hold, timer still runs
      end
    endcase
  end

endmodule

// ----- rtl/core/five_way_key_event_detector.sv -----
// Top level of the five-way key event detector: APB registers, input
// register, event state and result register. Uses fwkd_pkg,
// fwkd_dir_classify and fwkd_center_fsm.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_ready  | action, adc_sample, center_level
//   out     | out_valid / out_ready| event_code
//   cfg     | APB psel/penable     | paddr, pwdata, prdata
//
// An item waits in the input register and is evaluated against the key
// state on the way to the result register, which loads as the item leaves
// the input register; one item per cycle sustained while the output is not
// stalled. Synchronous reset clears the state, pending event and both valid
// flags. A stalled output holds the result; the input register still takes
// an item while it is empty.
`timescale 1ns / 1ps

module five_way_key_event_detector (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [11:0] adc_sample,
  input  logic        center_level,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_code
);

  fwkd_pkg::cfg_t cfg;

  // input register
  logic        s1_valid;
  logic        s1_action;
  logic [11:0] s1_sample;
  logic        s1_level;
  logic        s1_advance;

  // key state
  fwkd_pkg::event_t last_direction;
  fwkd_pkg::phase_t center_phase;
  logic [15:0]      tick_timer;
  fwkd_pkg::event_t pending_event;
  fwkd_pkg::event_t pending_event_next;
  fwkd_pkg::event_t result_next;

  fwkd_pkg::event_t       dir;
  fwkd_pkg::center_step_t step;
  logic [1:0]             reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks       <= fwkd_pkg::DEBOUNCE_RST;
      cfg.hold_ticks         <= fwkd_pkg::LONG_RST;
      cfg.second_press_ticks <= fwkd_pkg::DOUBLE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        fwkd_pkg::REG_DEBOUNCE: cfg.settle_ticks       <= pwdata[15:0];
        fwkd_pkg::REG_LONG:     cfg.hold_ticks         <= pwdata[15:0];
        fwkd_pkg::REG_DOUBLE:   cfg.second_press_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_index)
      fwkd_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg.settle_ticks};
      fwkd_pkg::REG_LONG:     prdata = {16'd0, cfg.hold_ticks};
      fwkd_pkg::REG_DOUBLE:   prdata = {16'd0, cfg.second_press_ticks};
      default:                prdata = '0;
    endcase
  end

  // Handshake: stage 1 moves on when the result register is free or drains
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_sample <= adc_sample;
      s1_level  <= center_level;
    end
  end

  fwkd_dir_classify u_dir (
    .adc_sample (s1_sample),
    .dir        (dir)
  );

  fwkd_center_fsm u_center (
    .phase   (center_phase),
    .timer   (tick_timer),
    .pressed (s1_level),
    .cfg     (cfg),
    .step    (step)
  );

  // Pending event update: read clears, scan may post direction then key event
  always_comb begin
    pending_event_next = pending_event;
    result_next        = pending_event;
    if (s1_action) begin
      pending_event_next = fwkd_pkg::EV_NONE;
    end else begin
      if (last_direction == fwkd_pkg::EV_NONE && dir != fwkd_pkg::EV_NONE) begin
        pending_event_next = dir;
      end
      if (step.fire) begin
        pending_event_next = step.code;
      end
      result_next = pending_event_next;
    end
  end

  // Key state, updated as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction <= fwkd_pkg::EV_NONE;
      center_phase   <= fwkd_pkg::PH_IDLE;
      tick_timer     <= '0;
      pending_event  <= fwkd_pkg::EV_NONE;
    end else if (s1_advance) begin
      pending_event <= pending_event_next;
      if (!s1_action) begin
        last_direction <= dir;
        center_phase   <= step.phase;
        tick_timer     <= step.timer;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      event_code <= result_next;
    end
  end

endmodule
